@@ rtl/lpdt_pkg.sv @@
package lpdt_pkg;

    // register file
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_W      = 24;
    localparam int ROT_W      = 19;
    localparam int SHIFT_W    = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_ROT_X   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_Y   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_Z   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_Z = 3'd5;

    // point field widths
    localparam int RING_W = 8;
    localparam int FRAC_W = 16;

    // cordic formats: angles q28, vectors q30
    localparam int ANG_IN_W   = 36;
    localparam int ANG_W      = 33;
    localparam int XY_W       = 34;
    localparam int TRIG_W     = 32;
    localparam int CORDIC_PRE = 4;

    localparam logic signed [ANG_W-1:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 33'sd421657428;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 33'sd1686629713;

    localparam logic [ANG_IN_W-1:0] TWO_PI_MAG   = 36'd1686629713;
    localparam logic [ANG_IN_W-1:0] TWO_PI_MAG_2 = 36'd3373259426;
    localparam logic [ANG_IN_W-1:0] TWO_PI_MAG_4 = 36'd6746518852;

    localparam logic signed [XY_W-1:0]   GAIN_Q30 = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q30  = 32'sd1073741824;

    // atan(2^-i) in q28
    function automatic logic signed [ANG_W-1:0] atan_q28(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0: v = 33'sd210828714;
            1: v = 33'sd124459457;
            2: v = 33'sd65760959;
            3: v = 33'sd33381290;
            4: v = 33'sd16755422;
            5: v = 33'sd8385879;
            6: v = 33'sd4193963;
            7: v = 33'sd2097109;
            8: v = 33'sd1048571;
            9: v = 33'sd524287;
            default: begin
                if (i < 29) begin
                    v = ANG_W'(1) <<< (28 - i);
                end else if (i == 29) begin
                    v = ANG_W'(1);
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

@@ rtl/lpdt_cordic.sv @@
module lpdt_cordic
    import lpdt_pkg::*;
#(
    parameter int STAGES = 18
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [ANG_IN_W-1:0] angle,
    output logic signed [TRIG_W-1:0]   sin_out,
    output logic signed [TRIG_W-1:0]   cos_out
);

    logic [ANG_IN_W-1:0]     mag0_reg;
    logic                    neg0_reg;
    logic [ANG_IN_W-1:0]     mag1_reg;
    logic                    neg1_reg;
    logic signed [ANG_W-1:0] r2_reg;

    logic signed [XY_W-1:0]  x_reg [STAGES+1];
    logic signed [XY_W-1:0]  y_reg [STAGES+1];
    logic signed [ANG_W-1:0] r_reg [STAGES+1];
    logic                    flip_reg [STAGES+1];

    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    logic [ANG_IN_W-1:0]     mag1_next;
    logic [ANG_IN_W-1:0]     rem_next;
    logic signed [ANG_W-1:0] r2_next;
    logic signed [ANG_W-1:0] wrap_next;
    logic signed [ANG_W-1:0] r3_next;
    logic                    flip3_next;

    always_comb begin
        mag1_next = mag0_reg;
        if (mag1_next >= TWO_PI_MAG_4) begin
            mag1_next = mag1_next - TWO_PI_MAG_4;
        end
        if (mag1_next >= TWO_PI_MAG_2) begin
            mag1_next = mag1_next - TWO_PI_MAG_2;
        end

        rem_next = mag1_reg;
        if (rem_next >= TWO_PI_MAG) begin
            rem_next = rem_next - TWO_PI_MAG;
        end
        // remainder keeps the sign of the dividend
        r2_next = neg1_reg ? -ANG_W'(rem_next) : ANG_W'(rem_next);

        wrap_next = r2_reg;
        if (wrap_next > PI_Q28) begin
            wrap_next = wrap_next - TWO_PI_Q28;
        end else if (wrap_next < -PI_Q28) begin
            wrap_next = wrap_next + TWO_PI_Q28;
        end
        // fold into the right half plane, undone by negating the result
        r3_next    = wrap_next;
        flip3_next = 1'b0;
        if (wrap_next > HALF_PI_Q28) begin
            r3_next    = wrap_next - PI_Q28;
            flip3_next = 1'b1;
        end else if (wrap_next < -HALF_PI_Q28) begin
            r3_next    = wrap_next + PI_Q28;
            flip3_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag0_reg    <= angle[ANG_IN_W-1] ? ANG_IN_W'(-angle) : ANG_IN_W'(angle);
            neg0_reg    <= angle[ANG_IN_W-1];
            mag1_reg    <= mag1_next;
            neg1_reg    <= neg0_reg;
            r2_reg      <= r2_next;
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            r_reg[0]    <= r3_next;
            flip_reg[0] <= flip3_next;
            for (int i = 0; i < STAGES; i++) begin
                if (r_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    r_reg[i+1] <= r_reg[i] - atan_q28(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    r_reg[i+1] <= r_reg[i] + atan_q28(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
            cos_reg <= TRIG_W'(flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES]);
            sin_reg <= TRIG_W'(flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES]);
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

@@ rtl/lpdt_rot.sv @@
module lpdt_rot
    import lpdt_pkg::*;
#(
    parameter int CW     = 37,
    parameter int SIDE_W = 8
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [CW-1:0]     u_in,
    input  logic signed [CW-1:0]     v_in,
    input  logic signed [TRIG_W-1:0] c_in,
    input  logic signed [TRIG_W-1:0] s_in,
    input  logic [SIDE_W-1:0]        side_in,
    output logic signed [CW-1:0]     u_out,
    output logic signed [CW-1:0]     v_out,
    output logic [SIDE_W-1:0]        side_out
);

    // u' = c*u + s*v, v' = c*v - s*u, each product rounded half away from zero
    localparam int LB   = (CW + 1) / 2;
    localparam int HB   = CW - LB;
    localparam int PL_W = LB + TRIG_W;
    localparam int PH_W = HB + TRIG_W;
    localparam int FW   = CW + TRIG_W + 1;
    localparam int MW   = CW + 2;
    localparam int TW   = CW + 3;
    localparam logic [FW-1:0] HALF_LSB = FW'(1) << 29;

    // product order: u*c, v*s, v*c, u*s
    logic [CW-1:0]     au_reg;
    logic [CW-1:0]     av_reg;
    logic [TRIG_W-1:0] ac_reg;
    logic [TRIG_W-1:0] as_reg;
    logic              nu_reg;
    logic              nv_reg;
    logic              nc_reg;
    logic              ns_reg;

    logic [PL_W-1:0] pl_reg  [4];
    logic [PH_W-1:0] ph_reg  [4];
    logic            neg1_reg [4];
    logic [MW-1:0]   m_reg   [4];
    logic            neg2_reg [4];

    logic signed [CW-1:0] u_reg;
    logic signed [CW-1:0] v_reg;
    logic [SIDE_W-1:0]    side_reg [4];

    logic [CW-1:0]     a_sel  [4];
    logic [TRIG_W-1:0] c_sel  [4];
    logic              n_sel  [4];
    logic [FW-1:0]     sum    [4];
    logic signed [TW-1:0] term [4];

    always_comb begin
        a_sel[0] = au_reg;  c_sel[0] = ac_reg;  n_sel[0] = nu_reg ^ nc_reg;
        a_sel[1] = av_reg;  c_sel[1] = as_reg;  n_sel[1] = nv_reg ^ ns_reg;
        a_sel[2] = av_reg;  c_sel[2] = ac_reg;  n_sel[2] = nv_reg ^ nc_reg;
        a_sel[3] = au_reg;  c_sel[3] = as_reg;  n_sel[3] = nu_reg ^ ns_reg;
        for (int k = 0; k < 4; k++) begin
            sum[k]  = (FW'(ph_reg[k]) << LB) + FW'(pl_reg[k]) + HALF_LSB;
            term[k] = neg2_reg[k] ? -$signed(TW'(m_reg[k])) : $signed(TW'(m_reg[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            au_reg <= u_in[CW-1] ? CW'(-u_in) : CW'(u_in);
            av_reg <= v_in[CW-1] ? CW'(-v_in) : CW'(v_in);
            ac_reg <= c_in[TRIG_W-1] ? TRIG_W'(-c_in) : TRIG_W'(c_in);
            as_reg <= s_in[TRIG_W-1] ? TRIG_W'(-s_in) : TRIG_W'(s_in);
            nu_reg <= u_in[CW-1];
            nv_reg <= v_in[CW-1];
            nc_reg <= c_in[TRIG_W-1];
            ns_reg <= s_in[TRIG_W-1];
            for (int k = 0; k < 4; k++) begin
                pl_reg[k]   <= a_sel[k][LB-1:0] * c_sel[k];
                ph_reg[k]   <= a_sel[k][CW-1:LB] * c_sel[k];
                neg1_reg[k] <= n_sel[k];
                m_reg[k]    <= MW'(sum[k] >> 30);
                neg2_reg[k] <= neg1_reg[k];
            end
            u_reg <= CW'(term[0] + term[1]);
            v_reg <= CW'(term[2] - term[3]);
            side_reg[0] <= side_in;
            for (int j = 1; j < 4; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign u_out    = u_reg;
    assign v_out    = v_reg;
    assign side_out = side_reg[3];

endmodule

@@ rtl/lidar_point_deskew_transform.sv @@
// throughput: one point per cycle; the sine/cosine and rotation pipelines are fully staged
// any output stall holds the whole pipeline and drops s_tready in the same cycle
// reset: synchronous active-low aresetn clears valid bits and motion registers to zero
module lidar_point_deskew_transform
    import lpdt_pkg::*;
#(
    parameter int COORD_BITS    = 32,
    parameter int CORDIC_STAGES = 18
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x, pos_y, pos_z, ring, time_frac, zero pad
    input  logic [((3 * COORD_BITS + RING_W + FRAC_W + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x, out_y, out_z, out_ring, out_frac, zero pad
    output logic [((3 * COORD_BITS + RING_W + FRAC_W + 7) / 8) * 8 - 1:0] m_tdata,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int C   = COORD_BITS;
    localparam int TDW = ((3 * C + RING_W + FRAC_W + 7) / 8) * 8;
    localparam int CW  = ((C > 27) ? C : 27) + 5;
    localparam int CL  = CORDIC_STAGES + CORDIC_PRE + 1;
    localparam int VL  = CL + 26;
    localparam int DSH_W = 30;

    localparam logic signed [CW:0] SAT_HI = {{(CW + 2 - C){1'b0}}, {(C - 1){1'b1}}};
    localparam logic signed [CW:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 req;
        logic [RING_W-1:0]    ring;
        logic [FRAC_W-1:0]    frac;
    } point_t;

    typedef struct packed {
        logic signed [CW-1:0]     w;
        logic                     req;
        logic [RING_W-1:0]        ring;
        logic [FRAC_W-1:0]        frac;
        logic signed [TRIG_W-1:0] cs0;
        logic signed [TRIG_W-1:0] sn0;
        logic signed [TRIG_W-1:0] cs1;
        logic signed [TRIG_W-1:0] sn1;
        logic signed [TRIG_W-1:0] cs0e;
        logic signed [TRIG_W-1:0] sn0e;
        logic signed [TRIG_W-1:0] cs1e;
        logic signed [TRIG_W-1:0] sn1e;
        logic signed [TRIG_W-1:0] cs2e;
        logic signed [TRIG_W-1:0] sn2e;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    logic en;

    logic signed [ROT_W-1:0]   rot_reg [3];
    logic signed [SHIFT_W-1:0] sh_reg  [3];

    logic [VL-1:0] vld_reg;

    logic signed [C-1:0]  x1_reg, y1_reg, z1_reg;
    logic                 req1_reg;
    logic [RING_W-1:0]    ring1_reg;
    logic [FRAC_W-1:0]    frac1_reg;

    logic signed [C-1:0]        x2_reg, y2_reg, z2_reg;
    logic                       req2_reg;
    logic [RING_W-1:0]          ring2_reg;
    logic [FRAC_W-1:0]          frac2_reg;
    logic signed [DSH_W-1:0]    dsh_reg [3];
    logic signed [ANG_IN_W-1:0] ang_reg [6];

    logic [19:0]         sweep;
    logic signed [20:0]  sweep_s;
    logic signed [39:0]  ang_prod [3];
    logic signed [44:0]  sh_prod  [3];

    point_t dly_reg [CL];
    point_t dly_next;

    logic signed [TRIG_W-1:0] sin_w [6];
    logic signed [TRIG_W-1:0] cos_w [6];

    logic signed [CW-1:0] u_o [6];
    logic signed [CW-1:0] v_o [6];
    side_t                side_i [6];
    side_t                side_o [6];
    logic signed [CW-1:0] u_i [6];
    logic signed [CW-1:0] v_i [6];
    logic signed [TRIG_W-1:0] c_i [6];
    logic signed [TRIG_W-1:0] s_i [6];

    logic signed [CW:0]   fx, fy, fz;
    logic [C-1:0]         ox_reg, oy_reg, oz_reg;
    logic [RING_W-1:0]    oring_reg;
    logic [FRAC_W-1:0]    ofrac_reg;
    logic                 m_tvalid_reg;

    function automatic logic [C-1:0] sat(input logic signed [CW:0] v);
        logic [C-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[C-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[C-1:0];
        end else begin
            r = v[C-1:0];
        end
        return r;
    endfunction

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // motion registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                rot_reg[i] <= '0;
                sh_reg[i]  <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ROT_X:   rot_reg[0] <= cfg_wdata[ROT_W-1:0];
                REG_ROT_Y:   rot_reg[1] <= cfg_wdata[ROT_W-1:0];
                REG_ROT_Z:   rot_reg[2] <= cfg_wdata[ROT_W-1:0];
                REG_SHIFT_X: sh_reg[0]  <= cfg_wdata[SHIFT_W-1:0];
                REG_SHIFT_Y: sh_reg[1]  <= cfg_wdata[SHIFT_W-1:0];
                REG_SHIFT_Z: sh_reg[2]  <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[VL-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[VL-1];
        end
    end

    // sweep share s = 10 * frac, then scaled angles and shifts
    always_comb begin
        sweep   = 20'({frac1_reg, 3'b000}) + 20'({frac1_reg, 1'b0});
        sweep_s = $signed({1'b0, sweep});
        for (int i = 0; i < 3; i++) begin
            ang_prod[i] = rot_reg[i] * sweep_s;
            sh_prod[i]  = sh_reg[i] * sweep_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= s_tdata[C-1:0];
            y1_reg    <= s_tdata[2*C-1:C];
            z1_reg    <= s_tdata[3*C-1:2*C];
            ring1_reg <= s_tdata[3*C+RING_W-1:3*C];
            frac1_reg <= s_tdata[3*C+RING_W+FRAC_W-1:3*C+RING_W];
            req1_reg  <= s_tuser;

            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
            ring2_reg <= ring1_reg;
            frac2_reg <= frac1_reg;
            req2_reg  <= req1_reg;
            for (int i = 0; i < 3; i++) begin
                ang_reg[i]     <= ANG_IN_W'((ang_prod[i] + 40'sd8) >>> 4);
                ang_reg[i + 3] <= ANG_IN_W'(rot_reg[i]) <<< 12;
                dsh_reg[i]     <= DSH_W'((sh_prod[i] + 45'sd32768) >>> 16);
            end

            dly_reg[0] <= dly_next;
            for (int k = 1; k < CL; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    always_comb begin
        dly_next.x    = CW'(x2_reg) - CW'(dsh_reg[0]);
        dly_next.y    = CW'(y2_reg) - CW'(dsh_reg[1]);
        dly_next.z    = CW'(z2_reg) - CW'(dsh_reg[2]);
        dly_next.req  = req2_reg;
        dly_next.ring = ring2_reg;
        dly_next.frac = frac2_reg;
    end

    // scaled angles x, y, z then full angles x, y, z
    for (genvar g = 0; g < 6; g++) begin : g_cordic
        lpdt_cordic #(
            .STAGES (CORDIC_STAGES)
        ) u_cordic (
            .aclk    (aclk),
            .en      (en),
            .angle   (ang_reg[g]),
            .sin_out (sin_w[g]),
            .cos_out (cos_w[g])
        );
    end

    // rotation order: z, x, y back to start; then y, x, z forward (identity at start mode)
    always_comb begin
        side_i[0].w    = dly_reg[CL-1].z;
        side_i[0].req  = dly_reg[CL-1].req;
        side_i[0].ring = dly_reg[CL-1].ring;
        side_i[0].frac = dly_reg[CL-1].frac;
        side_i[0].cs0  = cos_w[0];
        side_i[0].sn0  = sin_w[0];
        side_i[0].cs1  = cos_w[1];
        side_i[0].sn1  = sin_w[1];
        side_i[0].cs0e = dly_reg[CL-1].req ? cos_w[3] : ONE_Q30;
        side_i[0].sn0e = dly_reg[CL-1].req ? sin_w[3] : '0;
        side_i[0].cs1e = dly_reg[CL-1].req ? cos_w[4] : ONE_Q30;
        side_i[0].sn1e = dly_reg[CL-1].req ? sin_w[4] : '0;
        side_i[0].cs2e = dly_reg[CL-1].req ? cos_w[5] : ONE_Q30;
        side_i[0].sn2e = dly_reg[CL-1].req ? sin_w[5] : '0;
        u_i[0] = dly_reg[CL-1].x;
        v_i[0] = dly_reg[CL-1].y;
        c_i[0] = cos_w[2];
        s_i[0] = sin_w[2];

        // (y, z) about x
        side_i[1]   = side_o[0];
        side_i[1].w = u_o[0];
        u_i[1] = v_o[0];
        v_i[1] = side_o[0].w;
        c_i[1] = side_o[0].cs0;
        s_i[1] = side_o[0].sn0;

        // (x, z) about y, negated sine
        side_i[2]   = side_o[1];
        side_i[2].w = u_o[1];
        u_i[2] = side_o[1].w;
        v_i[2] = v_o[1];
        c_i[2] = side_o[1].cs1;
        s_i[2] = -side_o[1].sn1;

        // forward (x, z) about y
        side_i[3]   = side_o[2];
        side_i[3].w = side_o[2].w;
        u_i[3] = u_o[2];
        v_i[3] = v_o[2];
        c_i[3] = side_o[2].cs1e;
        s_i[3] = side_o[2].sn1e;

        // forward (y, z) about x
        side_i[4]   = side_o[3];
        side_i[4].w = u_o[3];
        u_i[4] = side_o[3].w;
        v_i[4] = v_o[3];
        c_i[4] = side_o[3].cs0e;
        s_i[4] = -side_o[3].sn0e;

        // forward (x, y) about z
        side_i[5]   = side_o[4];
        side_i[5].w = v_o[4];
        u_i[5] = side_o[4].w;
        v_i[5] = u_o[4];
        c_i[5] = side_o[4].cs2e;
        s_i[5] = -side_o[4].sn2e;
    end

    for (genvar g = 0; g < 6; g++) begin : g_rot
        lpdt_rot #(
            .CW     (CW),
            .SIDE_W (SIDE_W)
        ) u_rot (
            .aclk     (aclk),
            .en       (en),
            .u_in     (u_i[g]),
            .v_in     (v_i[g]),
            .c_in     (c_i[g]),
            .s_in     (s_i[g]),
            .side_in  (side_i[g]),
            .u_out    (u_o[g]),
            .v_out    (v_o[g]),
            .side_out (side_o[g])
        );
    end

    // full shift only in end mode
    always_comb begin
        fx = (CW + 1)'(u_o[5]);
        fy = (CW + 1)'(v_o[5]);
        fz = (CW + 1)'(side_o[5].w);
        if (side_o[5].req) begin
            fx = fx + (CW + 1)'(sh_reg[0]);
            fy = fy + (CW + 1)'(sh_reg[1]);
            fz = fz + (CW + 1)'(sh_reg[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ox_reg    <= sat(fx);
            oy_reg    <= sat(fy);
            oz_reg    <= sat(fz);
            oring_reg <= side_o[5].ring;
            ofrac_reg <= side_o[5].req ? '0 : side_o[5].frac;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDW'({ofrac_reg, oring_reg, oz_reg, oy_reg, ox_reg});

endmodule

@@ sim/tb_lidar_point_deskew_transform.sv @@
module tb_lidar_point_deskew_transform;
    import lpdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS    = 32;
    localparam int CORDIC_STAGES = 18;
    localparam int TDW           = 3 * COORD_BITS + RING_W + FRAC_W;
    localparam int LATENCY       = CORDIC_STAGES + 31;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SWEEP_SCALE   = 10;
    localparam longint Q28_PI       = 843314857;
    localparam longint Q28_HALF_PI  = 421657428;
    localparam longint Q28_TWO_PI   = 1686629713;
    localparam longint Q30_GAIN     = 652032874;
    localparam longint PROD_LIM     = 64'sd4503599627370495;

    typedef enum bit {TO_START = 1'b0, TO_END = 1'b1} req_kind_t;

    typedef struct {
        req_kind_t              kind;
        logic [COORD_BITS-1:0]  px, py, pz;
        logic [RING_W-1:0]      ring;
        logic [FRAC_W-1:0]      frac;
    } point_t;

    typedef struct {
        logic [COORD_BITS-1:0]  ox, oy, oz;
        logic [RING_W-1:0]      ring;
        logic [FRAC_W-1:0]      frac;
    } deskewed_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDW-1:0]        s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDW-1:0]        m_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    lidar_point_deskew_transform #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (.*);

    // motion registers as the block should hold them
    logic [ROT_W-1:0]   mot_rot[3];
    logic [SHIFT_W-1:0] mot_shift[3];

    point_t    pending_points[$];
    deskewed_t expected_points[$];
    point_t    offered;
    int        n_errors;
    int        n_checked;
    int        n_end_mode;
    int        cycles;
    bit        idle_en;
    bit        hold_off_req;
    int        tx_gap;
    int        rx_gap;
    int        rx_hold;

    // ---------------- predictor ----------------

    function automatic longint atan_step(int i);
        longint unsigned term;
        longint sum;
        int e;
        sum = 0;
        if (i == 0) return Q28_PI / 4;
        for (int k = 0; k < 32; k++) begin
            if (i * (2 * k + 1) > 62) break;
            e = 62 - i * (2 * k + 1);
            term = (64'd1 << e) / longint'(2 * k + 1);
            sum = (k % 2) ? sum - longint'(term) : sum + longint'(term);
        end
        return (sum + (64'sd1 <<< 33)) >>> 34;
    endfunction

    function automatic void sin_cos(input longint ang, output longint sn, output longint cs);
        longint r, x, y, t;
        bit flip;
        r = ang % Q28_TWO_PI;
        x = Q30_GAIN;
        y = 0;
        flip = 0;
        if (r > Q28_PI) r -= Q28_TWO_PI;
        if (r < -Q28_PI) r += Q28_TWO_PI;
        if (r > Q28_HALF_PI) begin
            r -= Q28_PI;
            flip = 1;
        end else if (r < -Q28_HALF_PI) begin
            r += Q28_PI;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (r >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; r -= atan_step(i);
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; r += atan_step(i);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    // q16 coordinate times q30 trig, rounded half away from zero
    function automatic longint mul_trig(longint a, longint c);
        longint unsigned ua, uc, hi, lo, r;
        bit neg;
        if (a > PROD_LIM) a = PROD_LIM;
        if (a < -PROD_LIM) a = -PROD_LIM;
        if (c > (64'sd1 <<< 31)) c = 64'sd1 <<< 31;
        if (c < -(64'sd1 <<< 31)) c = -(64'sd1 <<< 31);
        neg = (a < 0) != (c < 0);
        ua = (a < 0) ? -a : a;
        uc = (c < 0) ? -c : c;
        hi = (ua >> 20) * uc;
        lo = (ua & 64'hFFFFF) * uc;
        r = (hi >> 10) + ((((hi & 64'd1023) << 20) + lo + (64'd1 << 29)) >> 30);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic void turn(inout longint u, inout longint v, input longint c, input longint s);
        longint nu, nv;
        nu = mul_trig(u, c) + mul_trig(v, s);
        nv = mul_trig(v, c) - mul_trig(u, s);
        u = nu;
        v = nv;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic deskewed_t deskew_point(point_t p);
        deskewed_t d;
        longint c[3], rot[3], sh[3], sn[3], cs[3];
        longint s;
        c[0] = longint'($signed(p.px));
        c[1] = longint'($signed(p.py));
        c[2] = longint'($signed(p.pz));
        s = longint'(p.frac) * SWEEP_SCALE;
        for (int i = 0; i < 3; i++) begin
            rot[i] = longint'($signed(mot_rot[i]));
            sh[i]  = longint'($signed(mot_shift[i]));
            sin_cos((rot[i] * s + 8) >>> 4, sn[i], cs[i]);
            c[i] -= (sh[i] * s + (64'sd1 <<< 15)) >>> 16;
        end
        turn(c[0], c[1], cs[2], sn[2]);
        turn(c[1], c[2], cs[0], sn[0]);
        turn(c[0], c[2], cs[1], -sn[1]);
        if (p.kind == TO_END) begin
            for (int i = 0; i < 3; i++) sin_cos(rot[i] * 4096, sn[i], cs[i]);
            turn(c[0], c[2], cs[1], sn[1]);
            turn(c[1], c[2], cs[0], -sn[0]);
            turn(c[0], c[1], cs[2], -sn[2]);
            for (int i = 0; i < 3; i++) c[i] += sh[i];
        end
        d.ox = clamp_coord(c[0]);
        d.oy = clamp_coord(c[1]);
        d.oz = clamp_coord(c[2]);
        d.ring = p.ring;
        d.frac = (p.kind == TO_END) ? '0 : p.frac;
        return d;
    endfunction

    // ---------------- clock, limit ----------------

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_points.size());
            $display("** lidar_point_deskew_transform: FAILED **");
            $finish;
        end
    end

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_points = {expected_points, deskew_point(offered)};
                if (offered.kind == TO_END) n_end_mode++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    offered = pending_points.pop_front();
                    s_tdata <= {offered.frac, offered.ring, offered.pz, offered.py, offered.px};
                    s_tuser <= offered.kind;
                    s_tvalid <= 1'b1;
                    if (idle_en && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 10);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic report_mismatch(string field, longint got, longint want);
        n_errors++;
        $display("mismatch on result %0d, %s: got %0h expected %0h", n_checked, field, got, want);
    endtask

    always @(posedge aclk) begin
        deskewed_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
            rx_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[31:0], 0);
                end else begin
                    want = expected_points.pop_front();
                    if (m_tdata[31:0] !== want.ox) report_mismatch("out_x", m_tdata[31:0], want.ox);
                    if (m_tdata[63:32] !== want.oy) report_mismatch("out_y", m_tdata[63:32], want.oy);
                    if (m_tdata[95:64] !== want.oz) report_mismatch("out_z", m_tdata[95:64], want.oz);
                    if (m_tdata[103:96] !== want.ring)
                        report_mismatch("out_ring", m_tdata[103:96], want.ring);
                    if (m_tdata[119:104] !== want.frac)
                        report_mismatch("out_frac", m_tdata[119:104], want.frac);
                end
                n_checked++;
            end
            if (hold_off_req) begin
                hold_off_req = 0;
                rx_hold = 300;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_en && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 10);
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ROT_X:   mot_rot[0] = val[ROT_W-1:0];
            REG_ROT_Y:   mot_rot[1] = val[ROT_W-1:0];
            REG_ROT_Z:   mot_rot[2] = val[ROT_W-1:0];
            REG_SHIFT_X: mot_shift[0] = val[SHIFT_W-1:0];
            REG_SHIFT_Y: mot_shift[1] = val[SHIFT_W-1:0];
            REG_SHIFT_Z: mot_shift[2] = val[SHIFT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_motion(int rx, int ry, int rz, int sx, int sy, int sz);
        write_reg(REG_ROT_X, CFG_W'(rx));
        write_reg(REG_ROT_Y, CFG_W'(ry));
        write_reg(REG_ROT_Z, CFG_W'(rz));
        write_reg(REG_SHIFT_X, CFG_W'(sx));
        write_reg(REG_SHIFT_Y, CFG_W'(sy));
        write_reg(REG_SHIFT_Z, CFG_W'(sz));
    endtask

    function automatic int rand_angle();
        return int'($urandom_range(0, 411774)) - 205887;
    endfunction

    function automatic int rand_shift();
        return int'($urandom_range(0, 8388608)) - 4194304;
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:    return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 65536)
                                             : 32'h8000_0000 + $urandom_range(0, 65536);
            default: return COORD_BITS'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    task automatic add_point(req_kind_t k, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [7:0] r, logic [15:0] f);
        point_t p;
        p.kind = k; p.px = x; p.py = y; p.pz = z; p.ring = r; p.frac = f;
        pending_points = {pending_points, p};
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
            add_point(req_kind_t'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                      rand_coord(), 8'($urandom_range(0, 255)), 16'($urandom));
    endtask

    task automatic add_directed();
        for (int k = 0; k < 2; k++) begin
            add_point(req_kind_t'(k), 0, 0, 0, 0, 0);
            add_point(req_kind_t'(k), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 255, 16'hFFFF);
            add_point(req_kind_t'(k), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 16'hFFFF);
            add_point(req_kind_t'(k), 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 128, 16'h8000);
            add_point(req_kind_t'(k), 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 7, 16'h0001);
            add_point(req_kind_t'(k), 32'h000A_0000, 32'h0005_0000, 32'hFFFE_0000, 64, 16'h1999);
        end
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_points.size() > 0 || s_tvalid || expected_points.size() > 0);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        idle_en = 1;
        hold_off_req = 0;
        n_errors = 0;
        n_checked = 0;
        n_end_mode = 0;
        cycles = 0;
        for (int i = 0; i < 3; i++) begin
            mot_rot[i] = '0;
            mot_shift[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // registers at reset value
        add_directed();
        drain();

        set_motion(30000, -20000, 50000, 100000, -300000, 65536);
        add_directed();
        add_random(110);
        drain();

        // receiver stalls long while the sender keeps offering
        set_motion(rand_angle(), rand_angle(), rand_angle(),
                   rand_shift(), rand_shift(), rand_shift());
        add_random(120);
        repeat (20) @(posedge aclk);
        @(negedge aclk) hold_off_req = 1;
        drain();

        set_motion(205887, 205887, 205887, 4194304, 4194304, 4194304);
        add_random(100);
        drain();

        set_motion(-205887, -205887, -205887, -4194304, -4194304, -4194304);
        add_random(100);
        drain();

        // arbitrary bit patterns, angles wrap
        set_motion($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        add_random(120);
        drain();

        idle_en = 0;
        set_motion(rand_angle(), rand_angle(), rand_angle(),
                   rand_shift(), rand_shift(), rand_shift());
        add_random(150);
        drain();

        $display("checked %0d deskewed points (%0d in to_end mode) over 7 motion settings,",
                 n_checked, n_end_mode);
        $display("with random idling, a long receiver stall and extreme registers");
        if (n_errors == 0) begin
            $display("** lidar_point_deskew_transform: PASSED **");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("** lidar_point_deskew_transform: FAILED **");
        end
        $finish;
    end

endmodule
